FILE: rtl/gwp_pkg.sv
`default_nettype none

package gwp_pkg;

  // number format
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam int CHAR_W     = 8;
  localparam int VAL_W      = 32;
  localparam int INT_W      = VAL_W + 1 - FRAC_BITS;
  localparam int MAG_W      = INT_W + FRAC_BITS;
  localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int DIV_W      = $clog2(10 ** MAX_FRAC_DIGITS + 1);
  localparam int FD_W       = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int CNT_W      = $clog2(FRAC_BITS);

  localparam logic [INT_W-1:0] INT_CAP = {1'b1, {(INT_W - 1){1'b0}}};

  // input queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_MALFORMED   = 2'd1;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;

  // character constants
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;

  typedef enum logic [3:0] {
    C_NUL,
    C_SPACE,
    C_LPAREN,
    C_RPAREN,
    C_SEMI,
    C_HASH,
    C_MINUS,
    C_PLUS,
    C_POINT,
    C_DIGIT,
    C_OTHER
  } cls_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PAREN,
    PH_SEMI,
    PH_LETTER,
    PH_SIGN,
    PH_INT,
    PH_POINT,
    PH_FRAC
  } phase_e;

  typedef enum logic [1:0] {
    B_RUN,
    B_DIV,
    B_FIN
  } bstate_e;

  // one queued character, already case folded
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    cls_e              cls;
  } gwp_item_t;

  typedef struct packed {
    logic                  start;
    logic [FRAC_ACC_W-1:0] dividend;
    logic [FD_W-1:0]       digits;
  } gwp_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } gwp_div_rsp_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [FD_W-1:0] n);
    logic [DIV_W-1:0] r;
    case (int'(n))
      0:       r = DIV_W'(64'd1);
      1:       r = DIV_W'(64'd10);
      2:       r = DIV_W'(64'd100);
      3:       r = DIV_W'(64'd1000);
      4:       r = DIV_W'(64'd10000);
      5:       r = DIV_W'(64'd100000);
      6:       r = DIV_W'(64'd1000000);
      7:       r = DIV_W'(64'd10000000);
      8:       r = DIV_W'(64'd100000000);
      9:       r = DIV_W'(64'd1000000000);
      default: r = DIV_W'(64'd1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gwp_front.sv
`default_nettype none

module gwp_front import gwp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CHAR_W-1:0] char_byte_i,
  output gwp_item_t              item_o,
  output logic                   item_valid_o,
  input  wire logic              item_ready_i
);

  gwp_item_t         cur;
  gwp_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  // classify and fold lower-case letters
  always_comb begin
    cur.ch  = char_byte_i;
    cur.cls = C_OTHER;
    if (char_byte_i >= CH_LA && char_byte_i <= CH_LZ) begin
      cur.ch = char_byte_i & CASE_MASK;
    end
    if (char_byte_i == CH_NUL) begin
      cur.cls = C_NUL;
    end else if (char_byte_i == CH_SPACE || char_byte_i == CH_TAB) begin
      cur.cls = C_SPACE;
    end else if (char_byte_i == CH_LPAR) begin
      cur.cls = C_LPAREN;
    end else if (char_byte_i == CH_RPAR) begin
      cur.cls = C_RPAREN;
    end else if (char_byte_i == CH_SEMI) begin
      cur.cls = C_SEMI;
    end else if (char_byte_i == CH_HASH) begin
      cur.cls = C_HASH;
    end else if (char_byte_i == CH_MINUS) begin
      cur.cls = C_MINUS;
    end else if (char_byte_i == CH_PLUS) begin
      cur.cls = C_PLUS;
    end else if (char_byte_i == CH_POINT) begin
      cur.cls = C_POINT;
    end else if (char_byte_i >= CH_ZERO && char_byte_i <= CH_NINE) begin
      cur.cls = C_DIGIT;
    end
  end

  assign in_ready_o   = (cnt_q != QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gwp_div.sv
`default_nettype none

module gwp_div import gwp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gwp_div_req_t req_i,
  output gwp_div_rsp_t      rsp_o
);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_W:0]       rem_q;
  logic [DIV_W-1:0]     den_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [DIV_W:0]       rem2;
  logic                 ge;

  // restoring division, one quotient bit a cycle; remainder stays below divisor
  assign rem2 = rem_q << 1;
  assign ge   = (rem2 >= {1'b0, den_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= (DIV_W + 1)'(req_i.dividend);
      den_q  <= pow10(req_i.digits);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem2 - {1'b0, den_q} : rem2;
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gwp_back.sv
`default_nettype none

module gwp_back import gwp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gwp_item_t          item_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  output gwp_div_req_t            div_req_o,
  input  wire gwp_div_rsp_t       div_rsp_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    word_valid_o,
  output logic [CHAR_W-1:0]       word_letter_o,
  output logic signed [VAL_W-1:0] word_value_o,
  output logic [1:0]              error_code_o,
  output logic                    line_end_o
);

  // parser state
  phase_e                phase_q, phase_d;
  logic [CHAR_W-1:0]     letter_q, letter_d;
  logic                  neg_q, neg_d;
  logic [INT_W-1:0]      int_q, int_d;
  logic [FRAC_ACC_W-1:0] frac_q, frac_d;
  logic [FD_W-1:0]       fd_q, fd_d;
  logic [1:0]            elatch_q, elatch_d;

  // word being finished
  bstate_e               bst_q, bst_d;
  logic [CHAR_W-1:0]     wletter_q;
  logic                  wneg_q;
  logic [INT_W-1:0]      wint_q;
  logic [1:0]            perr_q;
  logic                  pend_q;
  logic [MAG_W-1:0]      mag_q;

  // output register
  logic                  ovalid_q;
  logic                  oword_q;
  logic [CHAR_W-1:0]     oletter_q;
  logic [VAL_W-1:0]      ovalue_q;
  logic [1:0]            oerr_q;
  logic                  oend_q;

  logic                  out_free, pop, fin, do_start, raise, res_any, res_end;
  logic [1:0]            res_err, raise_code;
  logic [3:0]            dig;
  logic [INT_W+3:0]      int_x;
  logic [FRAC_ACC_W+3:0] frac_x;
  logic [MAG_W-1:0]      mag_neg;
  logic [VAL_W-1:0]      word_val;
  logic                  load_plain, load_word;

  assign out_free = !ovalid_q || out_ready_i;
  assign dig      = item_i.ch[3:0];
  assign int_x    = (INT_W + 4)'(int_q) * (INT_W + 4)'(10) + (INT_W + 4)'(dig);
  assign frac_x   = (FRAC_ACC_W + 4)'(frac_q) * (FRAC_ACC_W + 4)'(10)
                  + (FRAC_ACC_W + 4)'(dig);

  always_comb begin
    phase_d    = phase_q;
    letter_d   = letter_q;
    neg_d      = neg_q;
    int_d      = int_q;
    frac_d     = frac_q;
    fd_d       = fd_q;
    elatch_d   = elatch_q;
    pop        = 1'b0;
    fin        = 1'b0;
    do_start   = 1'b0;
    raise      = 1'b0;
    raise_code = ERR_NONE;
    res_any    = 1'b0;
    res_err    = ERR_NONE;
    res_end    = 1'b0;

    if (bst_q == B_RUN && item_valid_i && out_free) begin
      pop = 1'b1;
      if (elatch_q != ERR_NONE) begin
        // skip the rest of a line that failed
        if (item_i.cls == C_NUL) begin
          elatch_d = ERR_NONE;
          phase_d  = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            do_start = 1'b1;
          end
          PH_PAREN: begin
            if (item_i.cls == C_RPAREN) begin
              phase_d = PH_IDLE;
            end else if (item_i.cls == C_NUL) begin
              raise      = 1'b1;
              raise_code = ERR_MALFORMED;
            end
          end
          PH_SEMI: begin
            if (item_i.cls == C_NUL) begin
              phase_d = PH_IDLE;
              res_any = 1'b1;
              res_end = 1'b1;
            end
          end
          PH_LETTER, PH_SIGN: begin
            if (phase_q == PH_LETTER && item_i.cls == C_MINUS) begin
              neg_d   = 1'b1;
              phase_d = PH_SIGN;
            end else if (phase_q == PH_LETTER && item_i.cls == C_PLUS) begin
              phase_d = PH_SIGN;
            end else if (item_i.cls == C_DIGIT) begin
              int_d   = INT_W'(dig);
              phase_d = PH_INT;
            end else if (item_i.cls == C_POINT) begin
              phase_d = PH_POINT;
            end else begin
              raise      = 1'b1;
              raise_code = ERR_MALFORMED;
            end
          end
          PH_INT: begin
            if (item_i.cls == C_DIGIT) begin
              if (int_q < INT_CAP) begin
                int_d = (int_x > (INT_W + 4)'(INT_CAP)) ? INT_CAP : int_x[INT_W-1:0];
              end
            end else if (item_i.cls == C_POINT) begin
              phase_d = PH_FRAC;
            end else begin
              fin      = 1'b1;
              do_start = 1'b1;
              phase_d  = PH_IDLE;
            end
          end
          PH_POINT, PH_FRAC: begin
            if (item_i.cls == C_DIGIT) begin
              if (fd_q < FD_W'(MAX_FRAC_DIGITS)) begin
                frac_d = frac_x[FRAC_ACC_W-1:0];
                fd_d   = fd_q + 1'b1;
              end
              phase_d = PH_FRAC;
            end else if (phase_q == PH_POINT) begin
              raise      = 1'b1;
              raise_code = ERR_MALFORMED;
            end else begin
              fin      = 1'b1;
              do_start = 1'b1;
              phase_d  = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        // what starts the next item, also right after a closed word
        if (do_start) begin
          case (item_i.cls)
            C_SPACE: begin
            end
            C_NUL: begin
              res_any = 1'b1;
              res_end = 1'b1;
            end
            C_LPAREN: begin
              phase_d = PH_PAREN;
            end
            C_SEMI: begin
              phase_d = PH_SEMI;
            end
            C_HASH: begin
              raise      = 1'b1;
              raise_code = ERR_UNSUPPORTED;
            end
            default: begin
              letter_d = item_i.ch;
              neg_d    = 1'b0;
              int_d    = '0;
              frac_d   = '0;
              fd_d     = '0;
              phase_d  = PH_LETTER;
            end
          endcase
        end

        if (raise) begin
          res_any  = 1'b1;
          res_err  = raise_code;
          res_end  = 1'b1;
          phase_d  = PH_IDLE;
          elatch_d = (item_i.cls != C_NUL) ? raise_code : ERR_NONE;
        end
      end
    end
  end

  // word sequencer
  always_comb begin
    bst_d     = bst_q;
    load_word = 1'b0;
    case (bst_q)
      B_RUN: begin
        if (pop && fin) begin
          bst_d = B_DIV;
        end
      end
      B_DIV: begin
        if (div_rsp_i.done) begin
          bst_d = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          load_word = 1'b1;
          bst_d     = B_RUN;
        end
      end
      default: begin
        bst_d = B_RUN;
      end
    endcase
  end

  assign load_plain = pop && res_any && !fin;

  // sign and clamp to the 32-bit range
  assign mag_neg = '0 - mag_q;
  always_comb begin
    if (wneg_q) begin
      word_val = (mag_q >= MAG_W'(33'h080000000)) ? 32'h80000000 : mag_neg[VAL_W-1:0];
    end else begin
      word_val = (mag_q > MAG_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : mag_q[VAL_W-1:0];
    end
  end

  assign div_req_o.start    = pop && fin;
  assign div_req_o.dividend = frac_q;
  assign div_req_o.digits   = fd_q;

  assign item_ready_o  = pop;
  assign out_valid_o   = ovalid_q;
  assign word_valid_o  = oword_q;
  assign word_letter_o = oletter_q;
  assign word_value_o  = ovalue_q;
  assign error_code_o  = oerr_q;
  assign line_end_o    = oend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q    <= B_RUN;
      phase_q  <= PH_IDLE;
      letter_q <= '0;
      neg_q    <= 1'b0;
      int_q    <= '0;
      frac_q   <= '0;
      fd_q     <= '0;
      elatch_q <= ERR_NONE;
      ovalid_q <= 1'b0;
    end else begin
      bst_q    <= bst_d;
      phase_q  <= phase_d;
      letter_q <= letter_d;
      neg_q    <= neg_d;
      int_q    <= int_d;
      frac_q   <= frac_d;
      fd_q     <= fd_d;
      elatch_q <= elatch_d;
      if (load_plain || load_word) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && fin) begin
      wletter_q <= letter_q;
      wneg_q    <= neg_q;
      wint_q    <= int_q;
      perr_q    <= res_err;
      pend_q    <= res_end;
    end
    if (bst_q == B_DIV && div_rsp_i.done) begin
      mag_q <= {wint_q, {FRAC_BITS{1'b0}}} + MAG_W'(div_rsp_i.quot);
    end
    if (load_word) begin
      oword_q   <= 1'b1;
      oletter_q <= wletter_q;
      ovalue_q  <= word_val;
      oerr_q    <= perr_q;
      oend_q    <= pend_q;
    end else if (load_plain) begin
      oword_q   <= 1'b0;
      oletter_q <= '0;
      ovalue_q  <= '0;
      oerr_q    <= res_err;
      oend_q    <= res_end;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcode_word_parser_top.sv
// g-code word parser
//
// in channel: one character per beat on char_byte_i (in_valid_i / in_ready_o);
// byte 0 ends a line. characters land in a two-entry queue after being
// classified, so the sender keeps going while the parser is busy.
// out channel: one result per beat (out_valid_o / out_ready_i) with
// word_valid_o, word_letter_o, word_value_o (signed 16.16, saturated),
// error_code_o (0 none, 1 malformed, 2 unsupported parameter) and
// line_end_o. characters that report nothing give no beat.
// sequence: a character is queued, then taken by the parser; its result,
// if any, is registered in the out register. the character that closes a
// word holds the parser while the bit-serial fraction divider runs (one
// quotient bit per cycle, FRAC_BITS bits, 16 at 16.16), then while the
// integer part is added, then while the value is signed, clamped and
// registered. the queue keeps accepting meanwhile until its two entries fill.
// stall: while the out register holds an untaken result the parser takes
// no new character; results are never dropped or repeated.
// reset: queue and out register empty, parser between words, no error
// pending; no clearing pass is needed.
`default_nettype none

module gcode_word_parser_top import gwp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CHAR_W-1:0]  char_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    word_valid_o,
  output logic [CHAR_W-1:0]       word_letter_o,
  output logic signed [VAL_W-1:0] word_value_o,
  output logic [1:0]              error_code_o,
  output logic                    line_end_o
);

  gwp_item_t    item;
  logic         item_valid;
  logic         item_ready;
  gwp_div_req_t div_req;
  gwp_div_rsp_t div_rsp;

  // front: classify and queue characters
  gwp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_byte_i  (char_byte_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // back: parser state machine and result register
  gwp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_valid_o  (word_valid_o),
    .word_letter_o (word_letter_o),
    .word_value_o  (word_value_o),
    .error_code_o  (error_code_o),
    .line_end_o    (line_end_o)
  );

  // fraction digits scaled to FRAC_BITS binary places
  gwp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/gwp_checker.sv
`default_nettype none

module gwp_checker import gwp_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               word_valid_o,
  input wire logic [CHAR_W-1:0]  word_letter_o,
  input wire logic signed [VAL_W-1:0] word_value_o,
  input wire logic [1:0]         error_code_o,
  input wire logic               line_end_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_valid_o)
      && $stable(word_letter_o) && $stable(word_value_o)
      && $stable(error_code_o) && $stable(line_end_o))
    else $error("result changed while stalled");

  // a beat without a word carries zero letter and value
  a_no_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_valid_o |-> word_letter_o == '0 && word_value_o == '0)
    else $error("letter or value set without a word");

  // every beat without a word ends the line
  a_no_word_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_valid_o |-> line_end_o)
    else $error("empty result without line end");

  // an error always ends the line
  a_err_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> line_end_o)
    else $error("error without line end");

  // only defined error codes appear
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o == ERR_NONE || error_code_o == ERR_MALFORMED
      || error_code_o == ERR_UNSUPPORTED)
    else $error("undefined error code");

endmodule

bind gcode_word_parser_top gwp_checker u_gwp_checker (.*);

`default_nettype wire
